[rtl/bsf_pkg.sv]
// Shared types and constants for the byte-stuffing framer.
// No dependencies.
package bsf_pkg;

  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FLAG   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 1'd1;

  localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'd36;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd47;

  localparam int NUM_PH = 5;
  localparam int PH_OPEN  = 0;
  localparam int PH_ESC   = 1;
  localparam int PH_DATA  = 2;
  localparam int PH_CLOSE = 3;
  localparam int PH_CHK   = 4;

  typedef logic [NUM_PH-1:0] ph_mask_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              open;
    logic              stuff;
    logic              last;
  } bsf_entry_t;

endpackage

[rtl/bsf_if.sv]
// Valid/ready channel interfaces for the framer input and output.
// Depends on bsf_pkg.
interface bsf_in_if import bsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_in_frame;
  modport source (output valid, data_byte, last_in_frame, input ready);
  modport sink   (input valid, data_byte, last_in_frame, output ready);
endinterface

interface bsf_out_if import bsf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              is_checksum;
  logic              end_of_run;
  modport source (output valid, out_byte, is_checksum, end_of_run, input ready);
  modport sink   (input valid, out_byte, is_checksum, end_of_run, output ready);
endinterface

[rtl/byte_stuff_framer_xor.sv]
// Byte-stuffing framer with XOR trailer: top level, configuration registers.
// Depends on bsf_pkg, bsf_if, bsf_front, bsf_queue, bsf_back.
// Each input item yields one to five output bytes (opening flag, escape, data,
// closing flag, trailer), one per cycle from a registered output stage while
// out_ready is high; the byte sequencer expands each item, so an unstuffed
// mid-frame byte gives one output byte and a stuffed byte two. A small queue
// between classifier and sequencer keeps input accepted while output is pending.
module byte_stuff_framer_xor import bsf_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bsf_in_if.sink               in_chan,
  bsf_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  logic [BYTE_W-1:0] flag_r, flag_nxt;
  logic [BYTE_W-1:0] esc_r, esc_nxt;
  logic              push, q_full, pop, head_valid;
  bsf_entry_t        push_entry, head_entry;

  always_comb begin
    flag_nxt = flag_r;
    esc_nxt  = esc_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_FLAG:   flag_nxt = cfg_wdata;
        CFG_ESCAPE: esc_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= FLAG_RESET;
      esc_r  <= ESCAPE_RESET;
    end else begin
      flag_r <= flag_nxt;
      esc_r  <= esc_nxt;
    end
  end

  bsf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_data     (in_chan.data_byte),
    .in_last     (in_chan.last_in_frame),
    .flag_byte   (flag_r),
    .escape_byte (esc_r),
    .push        (push),
    .push_entry  (push_entry),
    .q_full      (q_full)
  );

  bsf_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  bsf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_entry      (head_entry),
    .pop             (pop),
    .flag_byte       (flag_r),
    .escape_byte     (esc_r),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_byte        (out_chan.out_byte),
    .out_is_checksum (out_chan.is_checksum),
    .out_end_of_run  (out_chan.end_of_run)
  );

endmodule

[rtl/bsf_front.sv]
// Front end: accepts payload items, tracks frame open state, classifies bytes.
// Depends on bsf_pkg.
module bsf_front import bsf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data,
  input  logic              in_last,
  input  logic [BYTE_W-1:0] flag_byte,
  input  logic [BYTE_W-1:0] escape_byte,
  output logic              push,
  output bsf_entry_t        push_entry,
  input  logic              q_full
);

  logic in_frame_r;
  logic in_frame_nxt;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_entry.data  = in_data;
    push_entry.open  = !in_frame_r;
    push_entry.stuff = (in_data == flag_byte) || (in_data == escape_byte);
    push_entry.last  = in_last;
    in_frame_nxt     = push ? !in_last : in_frame_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule

[rtl/bsf_queue.sv]
// Short FIFO of classified items between front and back.
// Depends on bsf_pkg.
module bsf_queue import bsf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  bsf_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output bsf_entry_t head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bsf_entry_t            mem [DEPTH];
  logic [PTR_W-1:0]      wptr_r, wptr_nxt;
  logic [PTR_W-1:0]      rptr_r, rptr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem[rptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[rtl/bsf_back.sv]
// Back end: expands each classified item into frame bytes, keeps the XOR trailer.
// Depends on bsf_pkg.
module bsf_back import bsf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  bsf_entry_t        head_entry,
  output logic              pop,
  input  logic [BYTE_W-1:0] flag_byte,
  input  logic [BYTE_W-1:0] escape_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_is_checksum,
  output logic              out_end_of_run
);

  ph_mask_t          mask_r, mask_nxt;
  ph_mask_t          sel;
  ph_mask_t          mask_left;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic              ochk_r, ochk_nxt;
  logic              oeor_r, oeor_nxt;
  logic              emit, load;
  logic [BYTE_W-1:0] emit_byte;

  assign out_valid       = ovalid_r;
  assign out_byte        = obyte_r;
  assign out_is_checksum = ochk_r;
  assign out_end_of_run  = oeor_r;

  always_comb begin
    sel       = mask_r & (~mask_r + 1'b1);
    mask_left = mask_r & ~sel;
    emit      = (mask_r != '0) && (!ovalid_r || out_ready);
    load      = (mask_r == '0) || (emit && (mask_left == '0));
    pop       = load && head_valid;

    emit_byte = data_r;
    if (sel[PH_OPEN] || sel[PH_CLOSE]) begin
      emit_byte = flag_byte;
    end else if (sel[PH_ESC]) begin
      emit_byte = escape_byte;
    end else if (sel[PH_CHK]) begin
      emit_byte = xor_r;
    end

    xor_nxt = xor_r;
    if (emit) begin
      if (sel[PH_OPEN] || sel[PH_CHK]) begin
        xor_nxt = '0;
      end else if (sel[PH_ESC] || sel[PH_DATA]) begin
        xor_nxt = xor_r ^ emit_byte;
      end
    end

    mask_nxt = emit ? mask_left : mask_r;
    data_nxt = data_r;
    if (load) begin
      mask_nxt = '0;
      if (head_valid) begin
        mask_nxt[PH_OPEN]  = head_entry.open;
        mask_nxt[PH_ESC]   = head_entry.stuff;
        mask_nxt[PH_DATA]  = 1'b1;
        mask_nxt[PH_CLOSE] = head_entry.last;
        mask_nxt[PH_CHK]   = head_entry.last;
        data_nxt           = head_entry.data;
      end
    end

    ovalid_nxt = ovalid_r && !out_ready;
    obyte_nxt  = obyte_r;
    ochk_nxt   = ochk_r;
    oeor_nxt   = oeor_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = emit_byte;
      ochk_nxt   = sel[PH_CHK];
      oeor_nxt   = (mask_left == '0);
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    obyte_r <= obyte_nxt;
    ochk_r  <= ochk_nxt;
    oeor_r  <= oeor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      xor_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      mask_r   <= mask_nxt;
      xor_r    <= xor_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule
